FILE: rtl/core/trilateration_2d_solver_macros.svh
`ifndef TRILATERATION_2D_SOLVER_MACROS_SVH
`define TRILATERATION_2D_SOLVER_MACROS_SVH

// Shorthand for concurrent checks; clk and rst come from the enclosing module.

// Consequent holds in the same cycle as the antecedent.
`define TDS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define TDS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/tds_pkg.sv
package tds_pkg;

  localparam int CoordW  = 16;               // tower and position coordinates
  localparam int RangeW  = 16;               // measured ranges
  localparam int DiffW   = CoordW + 1;       // tower coordinate differences
  localparam int KW      = DiffW + 1;        // matrix entries, 2*(t - ta)
  localparam int SqW     = 2 * RangeW;       // range squared
  localparam int NormW   = 2 * CoordW;       // |t|^2
  localparam int CW      = SqW + 2;          // right-hand side terms
  localparam int PW      = 2 * KW;           // cross products of the determinant
  localparam int DW      = PW + 1;           // determinant
  localparam int NW      = CW + KW + 1;      // Cramer numerators
  localparam int QW      = CoordW + 1;       // quotient bits kept by the divider
  localparam int RW      = NW + 2;           // divider remainder
  localparam int DivW    = DW + 1;           // divider divisor, 2*|det|
  localparam int RegIdxW = 3;
  localparam int QDepth  = 4;
  localparam int QPtrW   = $clog2(QDepth);

  localparam logic [RegIdxW-1:0] REG_TOWER_A_X = 3'd0;
  localparam logic [RegIdxW-1:0] REG_TOWER_A_Y = 3'd1;
  localparam logic [RegIdxW-1:0] REG_TOWER_B_X = 3'd2;
  localparam logic [RegIdxW-1:0] REG_TOWER_B_Y = 3'd3;
  localparam logic [RegIdxW-1:0] REG_TOWER_C_X = 3'd4;
  localparam logic [RegIdxW-1:0] REG_TOWER_C_Y = 3'd5;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_SINGULAR = 2'd1;
  localparam logic [1:0] STATUS_SAT      = 2'd2;

  localparam logic [CoordW-1:0] CoordMaxBits = {1'b0, {(CoordW-1){1'b1}}};
  localparam logic [CoordW-1:0] CoordMinBits = {1'b1, {(CoordW-1){1'b0}}};
  localparam logic [QW-1:0]     CoordMag     = QW'(2 ** (CoordW - 1));

  localparam logic signed [CoordW-1:0] TowerAXReset = CoordW'(0);
  localparam logic signed [CoordW-1:0] TowerAYReset = CoordW'(0);
  localparam logic signed [CoordW-1:0] TowerBXReset = CoordW'(1000);
  localparam logic signed [CoordW-1:0] TowerBYReset = CoordW'(0);
  localparam logic signed [CoordW-1:0] TowerCXReset = CoordW'(0);
  localparam logic signed [CoordW-1:0] TowerCYReset = CoordW'(1000);

  typedef struct packed {
    logic [RangeW-1:0] range_a;
    logic [RangeW-1:0] range_b;
    logic [RangeW-1:0] range_c;
  } meas_t;

  typedef struct packed {
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic [1:0]               status;
  } fix_t;

  typedef struct packed {
    logic signed [CoordW-1:0] ax;
    logic signed [CoordW-1:0] ay;
    logic signed [CoordW-1:0] bx;
    logic signed [CoordW-1:0] by;
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
  } towers_t;

  // Linear system of one word, handed from front to back.
  typedef struct packed {
    logic signed [CW-1:0] cc;
    logic signed [CW-1:0] dd;
    logic signed [DW-1:0] det;
    logic signed [KW-1:0] a0;
    logic signed [KW-1:0] a1;
    logic signed [KW-1:0] b0;
    logic signed [KW-1:0] b1;
    logic                 singular;
  } sys_t;

endpackage

FILE: rtl/core/trilateration_2d_solver.sv
// Throughput: one word per cycle while fix_stall is low; the two restoring dividers (one quotient
// bit per stage) and the cross-product multipliers are fully pipelined.
// Reset (rst, synchronous, active high): clears all valid bits and the queue, drops any
// word in flight, and loads the towers at (0,0), (1000,0) and (0,1000) mm.
module trilateration_2d_solver (
  input  logic                           clk,
  input  logic                           rst,
  // Range words
  input  logic                           meas_valid,
  output logic                           meas_stall,
  input  tds_pkg::meas_t                 meas,
  // Position words
  output logic                           fix_valid,
  input  logic                           fix_stall,
  output tds_pkg::fix_t                  fix,
  // Tower register writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tds_pkg::RegIdxW-1:0]    cfg_index,
  input  logic [tds_pkg::CoordW-1:0]     cfg_data
);
  import tds_pkg::*;

  // Tower coordinates. The front derives the matrix entries, |t|^2 terms and the
  // determinant cross products from these every cycle, one register stage deep, which
  // is covered by the front pipeline ahead of the point where they are used.
  towers_t towers;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      towers.ax <= TowerAXReset;
      towers.ay <= TowerAYReset;
      towers.bx <= TowerBXReset;
      towers.by <= TowerBYReset;
      towers.cx <= TowerCXReset;
      towers.cy <= TowerCYReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TOWER_A_X: towers.ax <= cfg_data;
        REG_TOWER_A_Y: towers.ay <= cfg_data;
        REG_TOWER_B_X: towers.bx <= cfg_data;
        REG_TOWER_B_Y: towers.by <= cfg_data;
        REG_TOWER_C_X: towers.cx <= cfg_data;
        REG_TOWER_C_Y: towers.cy <= cfg_data;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // Front: capture ranges, square them, form C, D and det, flag det == 0.
  // Three stages; it only stops when the queue is full and its last stage holds a word.
  sys_t front_sys;
  logic front_push;
  logic q_full;

  tds_front u_front (
    .clk        (clk),
    .rst        (rst),
    .towers     (towers),
    .meas_valid (meas_valid),
    .meas_stall (meas_stall),
    .meas       (meas),
    .q_full     (q_full),
    .push       (front_push),
    .sys        (front_sys)
  );

  // Four-entry queue decouples the front from back-pressure on the result side.
  sys_t q_rdata;
  logic q_empty;
  logic back_pop;

  tds_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (front_push),
    .wdata (front_sys),
    .full  (q_full),
    .pop   (back_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // Back: Cramer numerators, magnitudes, pipelined rounding divide, clamp and status.
  // Its output register is the last stage; the whole back pipe holds while a finished
  // word waits with fix_stall high, and the queue keeps absorbing the front meanwhile until full.
  tds_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_rdata   (q_rdata),
    .pop       (back_pop),
    .fix_valid (fix_valid),
    .fix_stall (fix_stall),
    .fix       (fix)
  );

endmodule

FILE: rtl/core/tds_front.sv
module tds_front (
  input  logic             clk,
  input  logic             rst,
  input  tds_pkg::towers_t towers,
  input  logic             meas_valid,
  output logic             meas_stall,
  input  tds_pkg::meas_t   meas,
  input  logic             q_full,
  output logic             push,
  output tds_pkg::sys_t    sys
);
  import tds_pkg::*;

  function automatic logic [NormW-1:0] norm2(input logic signed [CoordW-1:0] x,
                                             input logic signed [CoordW-1:0] y);
    logic signed [NormW-1:0] xx;
    logic signed [NormW-1:0] yy;
    xx = x * x;
    yy = y * y;
    return $unsigned(xx) + $unsigned(yy);
  endfunction

  // Tower-derived terms, refreshed every cycle from the registers.
  logic signed [DiffW-1:0]   dxb, dyb, dxc, dyc;
  logic signed [2*DiffW-1:0] prod_a, prod_b;
  logic signed [KW-1:0]      a0, a1, b0, b1;
  logic signed [PW-1:0]      pa, pb;
  logic [NormW-1:0]          na, nb, nc;

  assign dxb    = DiffW'(towers.bx) - DiffW'(towers.ax);
  assign dyb    = DiffW'(towers.by) - DiffW'(towers.ay);
  assign dxc    = DiffW'(towers.cx) - DiffW'(towers.ax);
  assign dyc    = DiffW'(towers.cy) - DiffW'(towers.ay);
  assign prod_a = dxb * dyc;
  assign prod_b = dyb * dxc;

  always_ff @(posedge clk) begin
    a0 <= {dxb, 1'b0};
    a1 <= {dyb, 1'b0};
    b0 <= {dxc, 1'b0};
    b1 <= {dyc, 1'b0};
    pa <= {prod_a, 2'b00};
    pb <= {prod_b, 2'b00};
    na <= norm2(towers.ax, towers.ay);
    nb <= norm2(towers.bx, towers.by);
    nc <= norm2(towers.cx, towers.cy);
  end

  // Item pipeline: capture, square, form system.
  logic             v1, v2, v3;
  logic             adv;
  logic             accept;
  meas_t            r1;
  logic [SqW-1:0]   sqa, sqb, sqc;

  assign adv        = !v3 || !q_full;
  assign meas_stall = rst || !adv;
  assign accept     = meas_valid && !meas_stall;
  assign push       = v3 && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r1           <= meas;
      sqa          <= r1.range_a * r1.range_a;
      sqb          <= r1.range_b * r1.range_b;
      sqc          <= r1.range_c * r1.range_c;
      sys.cc       <= CW'(sqa) - CW'(sqb) - CW'(na) + CW'(nb);
      sys.dd       <= CW'(sqa) - CW'(sqc) - CW'(na) + CW'(nc);
      sys.det      <= DW'(pa) - DW'(pb);
      sys.singular <= (pa == pb);
      sys.a0       <= a0;
      sys.a1       <= a1;
      sys.b0       <= b0;
      sys.b1       <= b1;
    end
  end

endmodule

FILE: rtl/core/tds_queue.sv
`include "trilateration_2d_solver_macros.svh"

module tds_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tds_pkg::sys_t wdata,
  output logic          full,
  input  logic          pop,
  output tds_pkg::sys_t rdata,
  output logic          empty
);
  import tds_pkg::*;

  sys_t             mem [QDepth];
  logic [QPtrW-1:0] wr_ptr, rd_ptr;
  logic [QPtrW:0]   count;

  assign full  = (count == (QPtrW+1)'(QDepth));
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `TDS_ASSERT_NOW(a_push_not_full, push, !full, "queue written while full")
  `TDS_ASSERT_NOW(a_pop_not_empty, pop, !empty, "queue read while empty")
  `TDS_ASSERT_NEXT(a_fill_seen, push && !pop, !empty, "queue empty after a write")

endmodule

FILE: rtl/core/tds_div.sv
module tds_div (
  input  logic                   clk,
  input  logic                   adv,
  input  logic [tds_pkg::NW-1:0] num,
  input  logic [tds_pkg::DW-1:0] den,
  output logic [tds_pkg::QW-1:0] quo,
  output logic                   ovf
);
  import tds_pkg::*;

  // Rounded quotient floor((2n + d) / 2d), one bit per stage, MSB first.
  logic [RW-1:0]   rem   [QW+1];
  logic [DivW-1:0] dvs   [QW+1];
  logic [QW-1:0]   qacc  [QW+1];
  logic            ovfs  [1:QW];
  logic [RW-1:0]   trial [1:QW];
  logic            ge    [1:QW];

  always_comb begin
    for (int k = 1; k <= QW; k++) begin
      trial[k] = RW'(dvs[k-1]) << (QW - k);
      ge[k]    = (rem[k-1] >= trial[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem[0]  <= RW'({num, 1'b0}) + RW'(den);
      dvs[0]  <= {den, 1'b0};
      qacc[0] <= '0;
      ovfs[1] <= (rem[0] >= (RW'(dvs[0]) << QW));
      for (int k = 2; k <= QW; k++) begin
        ovfs[k] <= ovfs[k-1];
      end
      for (int k = 1; k <= QW; k++) begin
        dvs[k] <= dvs[k-1];
        if (ge[k]) begin
          rem[k]  <= rem[k-1] - trial[k];
          qacc[k] <= qacc[k-1] | (QW'(1) << (QW - k));
        end else begin
          rem[k]  <= rem[k-1];
          qacc[k] <= qacc[k-1];
        end
      end
    end
  end

  assign quo = qacc[QW];
  assign ovf = ovfs[QW];

endmodule

FILE: rtl/core/tds_back.sv
`include "trilateration_2d_solver_macros.svh"

module tds_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  tds_pkg::sys_t q_rdata,
  output logic          pop,
  output logic          fix_valid,
  input  logic          fix_stall,
  output tds_pkg::fix_t fix
);
  import tds_pkg::*;

  typedef struct packed {
    logic valid;
    logic singular;
    logic neg_x;
    logic neg_y;
  } side_t;

  // Result is {saturated, coordinate}.
  function automatic logic [CoordW:0] clamp_coord(input logic [QW-1:0] q,
                                                  input logic ovf_in,
                                                  input logic neg);
    logic              sat;
    logic [CoordW-1:0] v;
    if (neg) begin
      sat = ovf_in || (q > CoordMag);
      v   = sat ? CoordMinBits : CoordW'(QW'(0) - q);
    end else begin
      sat = ovf_in || (q >= CoordMag);
      v   = sat ? CoordMaxBits : q[CoordW-1:0];
    end
    return {sat, v};
  endfunction

  logic adv;
  assign adv = !fix_valid || !fix_stall;
  assign pop = adv && !q_empty;

  // Stage 1: cross products.
  logic                  vb1;
  logic signed [NW-2:0]  p0, p1, p2, p3;
  logic signed [DW-1:0]  det1;
  logic                  sing1;
  // Stage 2: numerators.
  logic                  vb2;
  logic signed [NW-1:0]  nx, ny;
  logic signed [DW-1:0]  det2;
  logic                  sing2;
  // Stage 3: magnitudes and quotient signs.
  logic                  vb3;
  logic [NW-1:0]         nx_mag, ny_mag;
  logic [DW-1:0]         det_mag;
  logic                  neg_x3, neg_y3, sing3;

  always_ff @(posedge clk) begin
    if (rst) begin
      vb1 <= 1'b0;
      vb2 <= 1'b0;
      vb3 <= 1'b0;
    end else if (adv) begin
      vb1 <= !q_empty;
      vb2 <= vb1;
      vb3 <= vb2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p0      <= q_rdata.cc * q_rdata.b1;
      p1      <= q_rdata.a1 * q_rdata.dd;
      p2      <= q_rdata.a0 * q_rdata.dd;
      p3      <= q_rdata.b0 * q_rdata.cc;
      det1    <= q_rdata.det;
      sing1   <= q_rdata.singular;
      nx      <= NW'(p0) - NW'(p1);
      ny      <= NW'(p2) - NW'(p3);
      det2    <= det1;
      sing2   <= sing1;
      nx_mag  <= nx[NW-1] ? NW'(-nx) : NW'(nx);
      ny_mag  <= ny[NW-1] ? NW'(-ny) : NW'(ny);
      det_mag <= det2[DW-1] ? DW'(-det2) : DW'(det2);
      neg_x3  <= nx[NW-1] ^ det2[DW-1];
      neg_y3  <= ny[NW-1] ^ det2[DW-1];
      sing3   <= sing2;
    end
  end

  logic [QW-1:0] quo_x, quo_y;
  logic          ovf_x, ovf_y;

  tds_div u_div_x (
    .clk (clk),
    .adv (adv),
    .num (nx_mag),
    .den (det_mag),
    .quo (quo_x),
    .ovf (ovf_x)
  );

  tds_div u_div_y (
    .clk (clk),
    .adv (adv),
    .num (ny_mag),
    .den (det_mag),
    .quo (quo_y),
    .ovf (ovf_y)
  );

  // Control riding alongside the divider stages.
  side_t side [QW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= QW; k++) begin
        side[k] <= '0;
      end
    end else if (adv) begin
      side[0] <= '{valid: vb3, singular: sing3, neg_x: neg_x3, neg_y: neg_y3};
      for (int k = 1; k <= QW; k++) begin
        side[k] <= side[k-1];
      end
    end
  end

  logic [CoordW:0] clx, cly;
  logic [1:0]      status_next;

  always_comb begin
    clx = clamp_coord(quo_x, ovf_x, side[QW].neg_x);
    cly = clamp_coord(quo_y, ovf_y, side[QW].neg_y);
    priority if (side[QW].singular) begin
      status_next = STATUS_SINGULAR;
    end else if (clx[CoordW] || cly[CoordW]) begin
      status_next = STATUS_SAT;
    end else begin
      status_next = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fix_valid <= 1'b0;
    end else if (adv) begin
      fix_valid <= side[QW].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fix.pos_x  <= side[QW].singular ? '0 : clx[CoordW-1:0];
      fix.pos_y  <= side[QW].singular ? '0 : cly[CoordW-1:0];
      fix.status <= status_next;
    end
  end

  // Terms for the output checks.
  logic fix_sing, fix_sat, pos_zero, pos_clamped;

  assign fix_sing    = (fix.status == STATUS_SINGULAR);
  assign fix_sat     = (fix.status == STATUS_SAT);
  assign pos_zero    = (fix.pos_x == '0) && (fix.pos_y == '0);
  assign pos_clamped = (fix.pos_x == CoordMaxBits) || (fix.pos_x == CoordMinBits) ||
                       (fix.pos_y == CoordMaxBits) || (fix.pos_y == CoordMinBits);

  `TDS_ASSERT_NOW(a_singular_zero, fix_valid && fix_sing, pos_zero, "singular word off origin")
  `TDS_ASSERT_NOW(a_sat_clamped, fix_valid && fix_sat, pos_clamped, "saturated word not clamped")
  `TDS_ASSERT_NEXT(a_hold, fix_valid && fix_stall, fix_valid && $stable(fix), "word moved")

endmodule
